// ===== hw/rtl/statevector_gate_engine_assert.svh =====
`ifndef STATEVECTOR_GATE_ENGINE_ASSERT_SVH
`define STATEVECTOR_GATE_ENGINE_ASSERT_SVH

// clocked check, held off while reset is low
`define SVGE_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("svge assertion failed");

// clocked check that also runs through reset
`define SVGE_ASSERT_ON(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("svge assertion failed");

`endif

// ===== hw/rtl/svge_pkg.sv =====
package svge_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_GATE  = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [3:0] G_H    = 4'd0;
    localparam logic [3:0] G_X    = 4'd1;
    localparam logic [3:0] G_Y    = 4'd2;
    localparam logic [3:0] G_Z    = 4'd3;
    localparam logic [3:0] G_RX   = 4'd4;
    localparam logic [3:0] G_RY   = 4'd5;
    localparam logic [3:0] G_RZ   = 4'd6;
    localparam logic [3:0] G_CX   = 4'd7;
    localparam logic [3:0] G_CZ   = 4'd8;
    localparam logic [3:0] G_SWAP = 4'd9;

    localparam logic [2:0] K_WRITE = 3'd0;
    localparam logic [2:0] K_READ  = 3'd1;
    localparam logic [2:0] K_CLEAR = 3'd2;
    localparam logic [2:0] K_GATE  = 3'd3;
    localparam logic [2:0] K_NOP   = 3'd4;

    // pair walk: single target, control/target, swap
    localparam logic [1:0] M_SINGLE = 2'd0;
    localparam logic [1:0] M_CTRL   = 2'd1;
    localparam logic [1:0] M_SWAP   = 2'd2;

    localparam int COEF_W     = 18;
    localparam int FRAC       = 14;
    localparam int ROUND_HALF = 8192;

    typedef logic signed [COEF_W-1:0] t_coef;

    localparam t_coef COEF_ONE   = 18'sd16384;
    localparam t_coef HALF_SQRT2 = 18'sd11585;

    localparam int CORDIC_STEPS = 14;
    localparam logic signed [19:0] CORDIC_GAIN = 20'sd9949;
    localparam logic signed [17:0] PI_Q14      = 18'sd51472;
    localparam logic signed [17:0] HALF_PI_Q14 = 18'sd25736;

    typedef struct packed {
        logic [2:0]                       kind;
        logic [1:0]                       mode;
        logic [3:0]                       qa;
        logic [3:0]                       qb;
        logic [3:0][1:0][COEF_W-1:0]      m;
        logic [9:0]                       index;
        logic [15:0]                      wr_re;
        logic [15:0]                      wr_im;
    } t_cmd;

    function automatic logic signed [17:0] atan_q14(input logic [3:0] i);
        case (i)
            4'd0:    return 18'sd12868;
            4'd1:    return 18'sd7596;
            4'd2:    return 18'sd4014;
            4'd3:    return 18'sd2037;
            4'd4:    return 18'sd1023;
            4'd5:    return 18'sd512;
            4'd6:    return 18'sd256;
            4'd7:    return 18'sd128;
            4'd8:    return 18'sd64;
            4'd9:    return 18'sd32;
            4'd10:   return 18'sd16;
            4'd11:   return 18'sd8;
            4'd12:   return 18'sd4;
            4'd13:   return 18'sd2;
            default: return 18'sd0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/svge_if.sv =====
interface svge_item_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic [3:0]         gate_code;
    logic [3:0]         first_qubit;
    logic [3:0]         second_qubit;
    logic signed [15:0] angle;
    logic [9:0]         amp_index;
    logic signed [15:0] write_re;
    logic signed [15:0] write_im;

    modport source (output valid, op, gate_code, first_qubit, second_qubit, angle, amp_index,
                    write_re, write_im, input ready);
    modport sink (input valid, op, gate_code, first_qubit, second_qubit, angle, amp_index,
                  write_re, write_im, output ready);
endinterface

interface svge_res_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] read_re;
    logic signed [15:0] read_im;
    logic               saturated;

    modport source (output valid, read_re, read_im, saturated, input ready);
    modport sink (input valid, read_re, read_im, saturated, output ready);
endinterface

// ===== hw/rtl/svge_cordic.sv =====
module svge_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [15:0] i_angle,
    output logic               o_done,
    output svge_pkg::t_coef    o_cos,
    output svge_pkg::t_coef    o_sin
);
    import svge_pkg::*;

    localparam logic [3:0] LAST = 4'(CORDIC_STEPS - 1);

    logic               r_busy, r_done, r_flip;
    logic [3:0]         r_i;
    logic signed [19:0] r_x, r_y;
    logic signed [17:0] r_z;
    t_coef              r_c, r_s;

    logic signed [17:0] z2, z0;
    logic               flip0;
    logic signed [19:0] xs, ys, n_x, n_y, fx, fy;
    logic signed [17:0] n_z;

    function automatic t_coef clamp(input logic signed [19:0] v);
        if (v > COEF_ONE) return COEF_ONE;
        if (v < -COEF_ONE) return -COEF_ONE;
        return v[COEF_W-1:0];
    endfunction

    always_comb begin
        z2    = {i_angle[15], i_angle, 1'b0};
        z0    = z2;
        flip0 = 1'b0;
        if (z2 > HALF_PI_Q14) begin
            z0    = z2 - PI_Q14;
            flip0 = 1'b1;
        end else if (z2 < -HALF_PI_Q14) begin
            z0    = z2 + PI_Q14;
            flip0 = 1'b1;
        end
        xs = r_x >>> r_i;
        ys = r_y >>> r_i;
        if (!r_z[17]) begin
            n_x = r_x - ys;
            n_y = r_y + xs;
            n_z = r_z - atan_q14(r_i);
        end else begin
            n_x = r_x + ys;
            n_y = r_y - xs;
            n_z = r_z + atan_q14(r_i);
        end
        fx = r_flip ? -n_x : n_x;
        fy = r_flip ? -n_y : n_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_i == LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= 4'd0;
                r_x    <= CORDIC_GAIN;
                r_y    <= 20'sd0;
                r_z    <= z0;
                r_flip <= flip0;
            end else if (r_busy) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
                r_i <= r_i + 4'd1;
                if (r_i == LAST) begin
                    r_busy <= 1'b0;
                    r_c    <= clamp(fx);
                    r_s    <= clamp(fy);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_c;
    assign o_sin  = r_s;
endmodule

// ===== hw/rtl/svge_front.sv =====
module svge_front #(
    parameter int QUBITS = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_hold,
    svge_item_if.sink      i_item,
    output svge_pkg::t_cmd o_cmd,
    output logic           o_cmd_vld,
    input  logic           i_cmd_rdy
);
    import svge_pkg::*;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_ROT  = 2'd1;
    localparam logic [1:0] F_HOLD = 2'd2;

    logic [1:0] r_state;
    t_cmd       r_cmd;
    logic [3:0] r_gate;

    t_cmd  cls;
    logic  accept, q1_ok, q2_ok, is_rot;
    logic  cor_done;
    t_coef cor_c, cor_s;
    logic [3:0][1:0][COEF_W-1:0] rot_m;

    assign i_item.ready = (r_state == F_IDLE) && !i_hold;
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        q1_ok     = int'(i_item.first_qubit) < QUBITS;
        q2_ok     = int'(i_item.second_qubit) < QUBITS;
        cls       = '0;
        cls.kind  = K_NOP;
        cls.mode  = M_SINGLE;
        cls.qa    = i_item.first_qubit;
        cls.qb    = i_item.second_qubit;
        cls.index = i_item.amp_index;
        cls.wr_re = i_item.write_re;
        cls.wr_im = i_item.write_im;
        is_rot    = 1'b0;
        case (i_item.op)
            OP_WRITE: cls.kind = K_WRITE;
            OP_READ:  cls.kind = K_READ;
            OP_CLEAR: cls.kind = K_CLEAR;
            default: begin
                case (i_item.gate_code)
                    G_H: begin
                        cls.kind    = q1_ok ? K_GATE : K_NOP;
                        cls.m[0][0] = HALF_SQRT2;
                        cls.m[1][0] = HALF_SQRT2;
                        cls.m[2][0] = HALF_SQRT2;
                        cls.m[3][0] = -HALF_SQRT2;
                    end
                    G_X: begin
                        cls.kind    = q1_ok ? K_GATE : K_NOP;
                        cls.m[1][0] = COEF_ONE;
                        cls.m[2][0] = COEF_ONE;
                    end
                    G_Y: begin
                        cls.kind    = q1_ok ? K_GATE : K_NOP;
                        cls.m[1][1] = -COEF_ONE;
                        cls.m[2][1] = COEF_ONE;
                    end
                    G_Z: begin
                        cls.kind    = q1_ok ? K_GATE : K_NOP;
                        cls.m[0][0] = COEF_ONE;
                        cls.m[3][0] = -COEF_ONE;
                    end
                    G_RX, G_RY, G_RZ: begin
                        cls.kind = q1_ok ? K_GATE : K_NOP;
                        is_rot   = q1_ok;
                    end
                    G_CX, G_SWAP: begin
                        if (q1_ok && q2_ok && i_item.first_qubit != i_item.second_qubit) begin
                            cls.kind = K_GATE;
                        end
                        cls.mode    = (i_item.gate_code == G_CX) ? M_CTRL : M_SWAP;
                        cls.m[1][0] = COEF_ONE;
                        cls.m[2][0] = COEF_ONE;
                    end
                    G_CZ: begin
                        cls.kind    = (q1_ok && q2_ok) ? K_GATE : K_NOP;
                        cls.mode    = (i_item.first_qubit == i_item.second_qubit) ?
                                      M_SINGLE : M_CTRL;
                        cls.m[0][0] = COEF_ONE;
                        cls.m[3][0] = -COEF_ONE;
                    end
                    default: cls.kind = K_NOP;
                endcase
            end
        endcase
    end

    always_comb begin
        rot_m       = '0;
        rot_m[0][0] = cor_c;
        rot_m[3][0] = cor_c;
        case (r_gate)
            G_RX: begin
                rot_m[1][1] = -cor_s;
                rot_m[2][1] = -cor_s;
            end
            G_RY: begin
                rot_m[1][0] = -cor_s;
                rot_m[2][0] = cor_s;
            end
            default: begin
                rot_m[0][1] = -cor_s;
                rot_m[3][1] = cor_s;
            end
        endcase
    end

    svge_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept && is_rot),
        .i_angle (i_item.angle),
        .o_done  (cor_done),
        .o_cos   (cor_c),
        .o_sin   (cor_s)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (accept) begin
                        r_cmd   <= cls;
                        r_gate  <= i_item.gate_code;
                        r_state <= is_rot ? F_ROT : F_HOLD;
                    end
                end
                F_ROT: begin
                    if (cor_done) begin
                        r_cmd.m <= rot_m;
                        r_state <= F_HOLD;
                    end
                end
                F_HOLD: begin
                    if (i_cmd_rdy) r_state <= F_IDLE;
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end

    assign o_cmd     = r_cmd;
    assign o_cmd_vld = (r_state == F_HOLD);
endmodule

// ===== hw/rtl/svge_cmd_fifo.sv =====
module svge_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  svge_pkg::t_cmd i_cmd,
    input  logic           i_vld,
    output logic           o_rdy,
    output svge_pkg::t_cmd o_cmd,
    output logic           o_vld,
    input  logic           i_rdy
);
    import svge_pkg::*;

    t_cmd       r_buf [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_rdy = (r_cnt != 2'd2);
    assign o_vld = (r_cnt != 2'd0);
    assign o_cmd = r_buf[r_rp];
    assign push  = i_vld && o_rdy;
    assign pop   = o_vld && i_rdy;

    always_ff @(posedge i_clk) begin
        if (push) r_buf[r_wp] <= i_cmd;
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

// ===== hw/rtl/svge_back.sv =====
module svge_back #(
    parameter int QUBITS   = 10,
    parameter int AMP_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  svge_pkg::t_cmd i_cmd,
    input  logic           i_cmd_vld,
    output logic           o_cmd_rdy,
    output logic           o_init,
    svge_res_if.source     o_res
);
    import svge_pkg::*;

    localparam int DIM = 1 << QUBITS;
    localparam int AW  = QUBITS;
    localparam int A   = AMP_BITS;
    localparam int PW  = COEF_W + 1 + A;
    localparam int SW  = PW + 2;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_SCAN = 4'd2;
    localparam logic [3:0] S_RDA  = 4'd3;
    localparam logic [3:0] S_RDB  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_WRA  = 4'd6;
    localparam logic [3:0] S_WRB  = 4'd7;
    localparam logic [3:0] S_RD   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    localparam logic [2:0] MUL_LAST = 3'd4;
    localparam logic [2*A-1:0] ONE_WORD = {(A'(1) << (A - 2)), {A{1'b0}}};

    logic [2*A-1:0] r_mem [DIM];
    logic [2*A-1:0] r_rdata, r_av;

    logic [3:0]     r_state;
    logic           r_clr_reply, r_out_vld, r_out_sat, r_sat;
    logic [15:0]    r_out_re, r_out_im;
    t_cmd           r_cmd;
    logic [AW-1:0]  r_idx, r_a, r_b;
    logic [2:0]     r_k;
    logic signed [PW-1:0] r_p [4];
    logic [A-1:0]   r_res [4];

    logic           mem_we, mem_re, pop, pair_ok, out_free;
    logic [AW-1:0]  mem_wa, mem_ra, bit_a, bit_b, pair_b, cmd_addr;
    logic [2*A-1:0] mem_wd;
    logic [QUBITS+9:0] idx_ext;
    logic [1:0]     row_a, row_b;
    logic signed [COEF_W:0] ca_re, ca_im, cb_re, cb_im, c0, c1, c2, c3;
    logic signed [A-1:0]    ar, ai, br, bi, d0, d1, d2, d3;
    logic signed [SW-1:0]   sum, sh;

    function automatic logic fits_amp(input logic signed [SW-1:0] v);
        return (&v[SW-1:A-1]) || !(|v[SW-1:A-1]);
    endfunction

    function automatic logic [A-1:0] sat_amp(input logic signed [SW-1:0] v);
        if (fits_amp(v)) return v[A-1:0];
        return v[SW-1] ? {1'b1, {(A-1){1'b0}}} : {1'b0, {(A-1){1'b1}}};
    endfunction

    function automatic logic [15:0] sat16(input logic signed [SW-1:0] v);
        if ((&v[SW-1:15]) || !(|v[SW-1:15])) return v[15:0];
        return v[SW-1] ? 16'h8000 : 16'h7fff;
    endfunction

    assign o_cmd_rdy = (r_state == S_IDLE);
    assign pop       = i_cmd_vld && o_cmd_rdy;
    assign o_init    = (r_state == S_CLR) && !r_clr_reply;
    assign out_free  = !r_out_vld || o_res.ready;
    assign idx_ext   = {{QUBITS{1'b0}}, i_cmd.index};
    assign cmd_addr  = idx_ext[AW-1:0];

    // pair addressing
    always_comb begin
        bit_a = AW'(1) << r_cmd.qa;
        bit_b = AW'(1) << r_cmd.qb;
        case (r_cmd.mode)
            M_SINGLE: begin
                pair_ok = (r_idx & bit_a) == '0;
                pair_b  = r_idx | bit_a;
            end
            M_SWAP: begin
                pair_ok = ((r_idx & bit_a) != '0) && ((r_idx & bit_b) == '0);
                pair_b  = (r_idx ^ bit_a) | bit_b;
            end
            default: begin
                pair_ok = ((r_idx & bit_a) != '0) && ((r_idx & bit_b) == '0);
                pair_b  = r_idx | bit_b;
            end
        endcase
    end

    // one output part per cycle: even k real, odd k imaginary
    always_comb begin
        row_a = {r_k[1], 1'b0};
        row_b = {r_k[1], 1'b1};
        ca_re = $signed({r_cmd.m[row_a][0][COEF_W-1], r_cmd.m[row_a][0]});
        ca_im = $signed({r_cmd.m[row_a][1][COEF_W-1], r_cmd.m[row_a][1]});
        cb_re = $signed({r_cmd.m[row_b][0][COEF_W-1], r_cmd.m[row_b][0]});
        cb_im = $signed({r_cmd.m[row_b][1][COEF_W-1], r_cmd.m[row_b][1]});
        ar    = $signed(r_av[2*A-1:A]);
        ai    = $signed(r_av[A-1:0]);
        br    = $signed(r_rdata[2*A-1:A]);
        bi    = $signed(r_rdata[A-1:0]);
        c0    = ca_re;
        c2    = cb_re;
        c1    = r_k[0] ? ca_im : -ca_im;
        c3    = r_k[0] ? cb_im : -cb_im;
        d0    = r_k[0] ? ai : ar;
        d1    = r_k[0] ? ar : ai;
        d2    = r_k[0] ? bi : br;
        d3    = r_k[0] ? br : bi;
        sum   = SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_p[2]) + SW'(r_p[3]);
        sh    = (sum + SW'(ROUND_HALF)) >>> FRAC;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = r_a;
        mem_ra = r_a;
        mem_wd = {r_res[3], r_res[2]};
        case (r_state)
            S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_idx;
                mem_wd = (r_idx == '0) ? ONE_WORD : '0;
            end
            S_IDLE: begin
                mem_we = pop && (i_cmd.kind == K_WRITE);
                mem_wa = cmd_addr;
                mem_wd = {sat_amp(SW'($signed(i_cmd.wr_re))), sat_amp(SW'($signed(i_cmd.wr_im)))};
            end
            S_WRA: mem_we = 1'b1;
            S_WRB: begin
                mem_we = 1'b1;
                mem_wa = r_b;
                mem_wd = {r_res[1], r_res[0]};
            end
            S_RDA, S_RD: mem_re = 1'b1;
            S_RDB: begin
                mem_re = 1'b1;
                mem_ra = r_b;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_rdata <= r_mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_idx       <= '0;
            r_clr_reply <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (o_res.ready && !((r_state == S_DONE) && out_free)) r_out_vld <= 1'b0;
            case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + AW'(1);
                    if (&r_idx) r_state <= r_clr_reply ? S_DONE : S_IDLE;
                end
                S_IDLE: begin
                    if (pop) begin
                        r_cmd <= i_cmd;
                        r_sat <= 1'b0;
                        r_a   <= cmd_addr;
                        r_idx <= '0;
                        case (i_cmd.kind)
                            K_READ: r_state <= S_RD;
                            K_CLEAR: begin
                                r_clr_reply <= 1'b1;
                                r_state     <= S_CLR;
                            end
                            K_GATE:  r_state <= S_SCAN;
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (pair_ok) begin
                        r_a     <= r_idx;
                        r_b     <= pair_b;
                        r_state <= S_RDA;
                    end else if (&r_idx) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
                S_RDA: r_state <= S_RDB;
                S_RDB: begin
                    r_av    <= r_rdata;
                    r_k     <= 3'd0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_k <= r_k + 3'd1;
                    if (r_k != MUL_LAST) begin
                        r_p[0] <= PW'(c0) * PW'(d0);
                        r_p[1] <= PW'(c1) * PW'(d1);
                        r_p[2] <= PW'(c2) * PW'(d2);
                        r_p[3] <= PW'(c3) * PW'(d3);
                    end
                    if (r_k != 3'd0) begin
                        r_res[0] <= sat_amp(sh);
                        r_res[1] <= r_res[0];
                        r_res[2] <= r_res[1];
                        r_res[3] <= r_res[2];
                        if (!fits_amp(sh)) r_sat <= 1'b1;
                    end
                    if (r_k == MUL_LAST) r_state <= S_WRA;
                end
                S_WRA: r_state <= S_WRB;
                S_WRB: begin
                    if (&r_idx) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_RD: r_state <= S_DONE;
                S_DONE: begin
                    if (out_free) begin
                        r_out_vld   <= 1'b1;
                        r_clr_reply <= 1'b0;
                        r_out_sat   <= (r_cmd.kind == K_GATE) && r_sat;
                        r_out_re    <= (r_cmd.kind == K_READ) ?
                                       sat16(SW'($signed(r_rdata[2*A-1:A]))) : 16'd0;
                        r_out_im    <= (r_cmd.kind == K_READ) ?
                                       sat16(SW'($signed(r_rdata[A-1:0]))) : 16'd0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.read_re   = r_out_re;
    assign o_res.read_im   = r_out_im;
    assign o_res.saturated = r_out_sat;

`include "statevector_gate_engine_assert.svh"

    `SVGE_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_out_vld) |-> ($past(r_state) == S_DONE))
    `SVGE_ASSERT(a_pair_distinct, i_clk, i_rst_n, (r_state == S_RDA) |-> (r_a != r_b))
    `SVGE_ASSERT(a_mul_bound, i_clk, i_rst_n, (r_state == S_MUL) |-> (r_k <= MUL_LAST))
    `SVGE_ASSERT_ON(a_reset_sweep, i_clk, !i_rst_n |=> ((r_state == S_CLR) && !r_out_vld))
endmodule

// ===== hw/rtl/statevector_gate_engine.sv =====
// Write, read and no-op items pass the front and the command FIFO to the back end.
// Gates: one pass over all 2^QUBITS indices; each amplitude pair is read, multiplied
// and written back, with a pair at half the indices for one qubit and a quarter for two
// distinct qubits. Rotations first run the CORDIC in the front. A clear resets to basis zero.
// After reset the vector is swept to basis zero over all 2^QUBITS indices; no item is
// taken until the sweep is done. One item runs at a time; up to three wait.
module statevector_gate_engine #(
    parameter int QUBITS   = 10,
    parameter int AMP_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svge_item_if.sink   i_item,
    svge_res_if.source  o_res
);
    import svge_pkg::*;

    t_cmd f_cmd, q_cmd;
    logic f_vld, f_rdy, q_vld, q_rdy, init;

    svge_front #(.QUBITS(QUBITS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_hold    (init),
        .i_item    (i_item),
        .o_cmd     (f_cmd),
        .o_cmd_vld (f_vld),
        .i_cmd_rdy (f_rdy)
    );

    svge_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (f_cmd),
        .i_vld   (f_vld),
        .o_rdy   (f_rdy),
        .o_cmd   (q_cmd),
        .o_vld   (q_vld),
        .i_rdy   (q_rdy)
    );

    svge_back #(.QUBITS(QUBITS), .AMP_BITS(AMP_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (q_cmd),
        .i_cmd_vld (q_vld),
        .o_cmd_rdy (q_rdy),
        .o_init    (init),
        .o_res     (o_res)
    );
endmodule

// ===== sim/statevector_gate_engine_tb.sv =====
`timescale 1ns / 100ps

module statevector_gate_engine_tb;
    import svge_pkg::*;

    localparam int NQ        = 10;
    localparam int DIM       = 1 << NQ;
    localparam int LIMIT     = 8_000_000;
    localparam int HOLD_AT   = 100_000;
    localparam int HOLD_LEN  = 4000;
    localparam int N_RANDOM  = 555;
    localparam int CALM_LEFT = 60;
    localparam int ARC_TAB [14] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128, 64, 32,
                                    16, 8, 4, 2};

    typedef struct {
        logic [1:0]         op;
        logic [3:0]         gate;
        logic [3:0]         qa;
        logic [3:0]         qb;
        logic signed [15:0] angle;
        logic [9:0]         idx;
        logic signed [15:0] wre;
        logic signed [15:0] wim;
        bit                 drain;
    } t_gate_item;

    typedef struct {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               sat;
    } t_amp_result;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   cyc = 0;
    int   errors = 0;
    bit   took = 1'b0;
    bit   calm = 1'b0;
    int   gap = 0;
    int   rgap = 0;
    int   hold_cnt = 0;

    int          amp_re [DIM];
    int          amp_im [DIM];
    t_gate_item  pending_items [$];
    t_amp_result amp_expected [$];

    svge_item_if item_if ();
    svge_res_if  res_if ();

    statevector_gate_engine dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_if),
        .o_res   (res_if)
    );

    always #10 clk = ~clk;

    function automatic int sat_amp(input longint v, inout bit sat);
        if (v > 32767) begin
            sat = 1'b1;
            return 32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            return -32768;
        end
        return int'(v);
    endfunction

    function automatic longint rnd14(input longint v);
        return (v + 8192) >>> 14;
    endfunction

    function automatic int clamp_coef(input int v);
        if (v > 16384) return 16384;
        if (v < -16384) return -16384;
        return v;
    endfunction

    task automatic enqueue(input t_gate_item it);
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic half_angle(input logic signed [15:0] angle, output int c, output int s);
        int z, x, y, xs, ys;
        bit flip;
        z = 2 * int'(angle);
        x = int'(CORDIC_GAIN);
        y = 0;
        flip = 1'b0;
        if (z > int'(HALF_PI_Q14)) begin
            z -= int'(PI_Q14);
            flip = 1'b1;
        end else if (z < -int'(HALF_PI_Q14)) begin
            z += int'(PI_Q14);
            flip = 1'b1;
        end
        for (int i = 0; i < 14; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ARC_TAB[i];
            end else begin
                x += ys; y -= xs; z += ARC_TAB[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = clamp_coef(x);
        s = clamp_coef(y);
    endtask

    task automatic rotate_pairs(input logic [3:0] gate, input int q,
                                input logic signed [15:0] angle, inout bit sat);
        int m [4][2];
        int c, s, bitm, ar, ai, br, bi;
        longint r0, i0, r1, i1;
        m = '{default: 0};
        c = 0;
        s = 0;
        bitm = 1 << q;
        if (gate >= G_RX) half_angle(angle, c, s);
        case (gate)
            G_H: begin
                m[0][0] = HALF_SQRT2; m[1][0] = HALF_SQRT2;
                m[2][0] = HALF_SQRT2; m[3][0] = -HALF_SQRT2;
            end
            G_X: begin
                m[1][0] = COEF_ONE; m[2][0] = COEF_ONE;
            end
            G_Y: begin
                m[1][1] = -COEF_ONE; m[2][1] = COEF_ONE;
            end
            G_Z: begin
                m[0][0] = COEF_ONE; m[3][0] = -COEF_ONE;
            end
            G_RX: begin
                m[0][0] = c; m[1][1] = -s; m[2][1] = -s; m[3][0] = c;
            end
            G_RY: begin
                m[0][0] = c; m[1][0] = -s; m[2][0] = s; m[3][0] = c;
            end
            default: begin
                m[0][0] = c; m[0][1] = -s; m[3][0] = c; m[3][1] = s;
            end
        endcase
        for (int k = 0; k < DIM; k++) begin
            if ((k & bitm) == 0) begin
                ar = amp_re[k]; ai = amp_im[k];
                br = amp_re[k | bitm]; bi = amp_im[k | bitm];
                r0 = longint'(m[0][0]) * ar - longint'(m[0][1]) * ai
                   + longint'(m[1][0]) * br - longint'(m[1][1]) * bi;
                i0 = longint'(m[0][0]) * ai + longint'(m[0][1]) * ar
                   + longint'(m[1][0]) * bi + longint'(m[1][1]) * br;
                r1 = longint'(m[2][0]) * ar - longint'(m[2][1]) * ai
                   + longint'(m[3][0]) * br - longint'(m[3][1]) * bi;
                i1 = longint'(m[2][0]) * ai + longint'(m[2][1]) * ar
                   + longint'(m[3][0]) * bi + longint'(m[3][1]) * br;
                amp_re[k] = sat_amp(rnd14(r0), sat);
                amp_im[k] = sat_amp(rnd14(i0), sat);
                amp_re[k | bitm] = sat_amp(rnd14(r1), sat);
                amp_im[k | bitm] = sat_amp(rnd14(i1), sat);
            end
        end
    endtask

    task automatic permute_pairs(input logic [3:0] gate, input int qa, input int qb,
                                 inout bit sat);
        int ba, bb, other, tr, ti;
        bit f, g;
        ba = 1 << qa;
        bb = 1 << qb;
        for (int k = 0; k < DIM; k++) begin
            f = (k & ba) != 0;
            g = (k & bb) != 0;
            if (gate == G_CZ && f && g) begin
                amp_re[k] = sat_amp(-longint'(amp_re[k]), sat);
                amp_im[k] = sat_amp(-longint'(amp_im[k]), sat);
            end else if (f && !g && (gate == G_CX || gate == G_SWAP)) begin
                other = (gate == G_CX) ? (k | bb) : ((k ^ ba) | bb);
                tr = amp_re[k]; ti = amp_im[k];
                amp_re[k] = amp_re[other]; amp_im[k] = amp_im[other];
                amp_re[other] = tr; amp_im[other] = ti;
            end
        end
    endtask

    task automatic to_basis_zero();
        for (int k = 0; k < DIM; k++) begin
            amp_re[k] = 0;
            amp_im[k] = 0;
        end
        amp_re[0] = 16384;
    endtask

    task automatic predict_amp(input t_gate_item it, output t_amp_result r);
        bit sat;
        sat = 1'b0;
        r = '{re: 16'sd0, im: 16'sd0, sat: 1'b0};
        case (it.op)
            OP_WRITE: begin
                amp_re[it.idx] = it.wre;
                amp_im[it.idx] = it.wim;
            end
            OP_GATE: begin
                if (it.gate <= G_RZ) begin
                    if (it.qa < NQ) rotate_pairs(it.gate, it.qa, it.angle, sat);
                end else if (it.gate <= G_SWAP) begin
                    if (it.qa < NQ && it.qb < NQ) permute_pairs(it.gate, it.qa, it.qb, sat);
                end
            end
            OP_READ: begin
                r.re = amp_re[it.idx][15:0];
                r.im = amp_im[it.idx][15:0];
            end
            default: to_basis_zero();
        endcase
        r.sat = sat;
    endtask

    function automatic t_gate_item mk(input logic [1:0] op, input logic [3:0] gate,
                                      input logic [3:0] qa, input logic [3:0] qb,
                                      input logic signed [15:0] angle, input logic [9:0] idx,
                                      input logic signed [15:0] wre,
                                      input logic signed [15:0] wim);
        t_gate_item it;
        it = '{op: op, gate: gate, qa: qa, qb: qb, angle: angle, idx: idx,
               wre: wre, wim: wim, drain: 1'b0};
        return it;
    endfunction

    function automatic t_gate_item rand_item();
        t_gate_item it;
        int r;
        it.gate  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
        it.qa    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
        it.qb    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                                : 4'($urandom_range(0, 9));
        it.angle = 16'($urandom);
        it.idx   = 10'($urandom);
        it.wre   = 16'($urandom);
        it.wim   = 16'($urandom);
        it.drain = ($urandom_range(0, 99) == 0);
        r = $urandom_range(0, 99);
        if (r < 45)      it.op = OP_WRITE;
        else if (r < 82) it.op = OP_READ;
        else if (r < 98) it.op = OP_GATE;
        else             it.op = OP_CLEAR;
        return it;
    endfunction

    initial begin
        t_gate_item it;
        item_if.valid = 1'b0;
        item_if.op = OP_READ;
        item_if.gate_code = G_H;
        item_if.first_qubit = '0;
        item_if.second_qubit = '0;
        item_if.angle = '0;
        item_if.amp_index = '0;
        item_if.write_re = '0;
        item_if.write_im = '0;
        res_if.ready = 1'b0;
        to_basis_zero();

        enqueue(mk(OP_READ,  G_H,    0, 0, 0,      0,    0,      0));
        enqueue(mk(OP_WRITE, G_H,    0, 0, 0,      1023, 32767,  -32768));
        enqueue(mk(OP_READ,  G_H,    0, 0, 0,      1023, 0,      0));
        enqueue(mk(OP_WRITE, G_H,    0, 0, 0,      1,    -32768, -32768));
        // same qubit twice: CZ negates, most negative value clips
        enqueue(mk(OP_GATE,  G_CZ,   0, 0, 0,      0,    0,      0));
        enqueue(mk(OP_READ,  G_H,    0, 0, 0,      1,    0,      0));
        enqueue(mk(OP_GATE,  G_H,    0, 0, 0,      0,    0,      0));
        enqueue(mk(OP_GATE,  G_X,    3, 0, 0,      0,    0,      0));
        enqueue(mk(OP_GATE,  G_Y,    9, 0, 0,      0,    0,      0));
        enqueue(mk(OP_GATE,  G_Z,    1, 0, 0,      0,    0,      0));
        enqueue(mk(OP_GATE,  G_RX,   2, 0, 32767,  0,    0,      0));
        enqueue(mk(OP_GATE,  G_RY,   4, 0, -32768, 0,    0,      0));
        enqueue(mk(OP_GATE,  G_RZ,   5, 0, 0,      0,    0,      0));
        enqueue(mk(OP_GATE,  G_CX,   0, 9, 0,      0,    0,      0));
        enqueue(mk(OP_GATE,  G_SWAP, 2, 7, 0,      0,    0,      0));
        enqueue(mk(OP_GATE,  G_CX,   3, 3, 0,      0,    0,      0));
        enqueue(mk(OP_GATE,  G_SWAP, 6, 6, 0,      0,    0,      0));
        enqueue(mk(OP_GATE,  G_H,    15, 0, 0,     0,    0,      0));
        enqueue(mk(OP_GATE,  G_CX,   1, 10, 0,     0,    0,      0));
        enqueue(mk(OP_GATE,  4'd15,  1, 2, 0,      0,    0,      0));
        enqueue(mk(OP_READ,  G_H,    0, 0, 0,      1023, 0,      0));
        enqueue(mk(OP_READ,  G_H,    0, 0, 0,      512,  0,      0));
        it = mk(OP_CLEAR, G_H, 0, 0, 0, 0, 0, 0);
        it.drain = 1'b1;
        enqueue(it);
        enqueue(mk(OP_READ,  G_H,    0, 0, 0,      0,    0,      0));
        for (int n = 0; n < N_RANDOM; n++) enqueue(rand_item());

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() > 0 || item_if.valid || amp_expected.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0 && amp_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    always @(negedge clk) begin
        calm = pending_items.size() < CALM_LEFT;
        if (!rst_n) begin
            item_if.valid <= 1'b0;
        end else if (!item_if.valid || took) begin
            if (gap > 0) begin
                gap--;
                item_if.valid <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].drain && amp_expected.size() > 0)) begin
                if (!calm && $urandom_range(0, 7) == 0) begin
                    gap = $urandom_range(0, 3);
                    item_if.valid <= 1'b0;
                end else begin
                    t_gate_item it;
                    it = pending_items.pop_front();
                    item_if.op           <= it.op;
                    item_if.gate_code    <= it.gate;
                    item_if.first_qubit  <= it.qa;
                    item_if.second_qubit <= it.qb;
                    item_if.angle        <= it.angle;
                    item_if.amp_index    <= it.idx;
                    item_if.write_re     <= it.wre;
                    item_if.write_im     <= it.wim;
                    item_if.valid        <= 1'b1;
                end
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            res_if.ready <= 1'b0;
        end else if (cyc == HOLD_AT) begin
            hold_cnt = HOLD_LEN;
            res_if.ready <= 1'b0;
        end else if (rgap > 0) begin
            rgap--;
            res_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            rgap = $urandom_range(0, 3);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_gate_item  it;
        t_amp_result r;
        t_amp_result e;
        cyc++;
        if (cyc > LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            took = rst_n && item_if.valid && item_if.ready;
            if (took) begin
                it = mk(item_if.op, item_if.gate_code, item_if.first_qubit,
                        item_if.second_qubit, item_if.angle, item_if.amp_index,
                        item_if.write_re, item_if.write_im);
                predict_amp(it, r);
                amp_expected.insert(amp_expected.size(), r);
            end
            if (rst_n && res_if.valid && res_if.ready) begin
                if (amp_expected.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result re=%0d im=%0d sat=%0b",
                                 res_if.read_re, res_if.read_im, res_if.saturated);
                end else begin
                    e = amp_expected.pop_front();
                    if (res_if.read_re !== e.re || res_if.read_im !== e.im ||
                        res_if.saturated !== e.sat) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp re=%0d im=%0d sat=%0b, got re=%0d im=%0d sat=%0b",
                                     e.re, e.im, e.sat, res_if.read_re, res_if.read_im,
                                     res_if.saturated);
                    end
                end
            end
        end
    end

endmodule
